### hdl/zvs_pkg.sv
`timescale 1ns / 1ps

package zvs_pkg;

	localparam int SCREEN_W   = 1024;
	localparam int SCREEN_H   = 1024;
	localparam int STORE_SIZE = SCREEN_W * SCREEN_H;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int XW         = $clog2(SCREEN_W);
	localparam int YW         = $clog2(SCREEN_H);
	localparam int POS_W      = 16;
	localparam int COLOR_W    = 24;
	localparam int DEPTH_W    = 16;
	localparam int ZFIX_W     = 24;
	localparam int FRAC_W     = 8;
	localparam int COUNT_W    = 4;

	localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
	localparam logic [COLOR_W-1:0] MARKER_RESET = {COLOR_W{1'b1}};

	typedef enum logic {
		CMD_DRAW = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_DEPTH_TEST   = 1'b0,
		REG_MARKER_COLOR = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [COLOR_W-1:0]        color;
		logic signed [DEPTH_W-1:0] depth;
	} pixel_t;

	typedef struct packed {
		logic                      was_drawn;
		logic [COUNT_W-1:0]        pixels_written;
		logic [COLOR_W-1:0]        pixel_color;
		logic signed [DEPTH_W-1:0] pixel_depth;
	} result_t;

	// Rounds a fixed point depth to an integer, halves away from zero,
	// saturating at the top of the integer range.
	function automatic logic signed [DEPTH_W-1:0] round_depth(
		input logic signed [ZFIX_W-1:0] d
	);
		logic signed [ZFIX_W:0]      dx;
		logic [ZFIX_W:0]             mag;
		logic [ZFIX_W:0]             sum;
		logic [ZFIX_W-FRAC_W:0]      q;
		logic [ZFIX_W-FRAC_W:0]      nq;
		logic signed [DEPTH_W-1:0]   r;
		dx  = {d[ZFIX_W-1], d};
		mag = dx[ZFIX_W] ? (ZFIX_W+1)'(-dx) : (ZFIX_W+1)'(dx);
		sum = mag + (ZFIX_W+1)'(1 << (FRAC_W - 1));
		q   = sum[ZFIX_W:FRAC_W];
		nq  = (ZFIX_W-FRAC_W+1)'(-q);
		if (dx[ZFIX_W]) begin
			r = nq[DEPTH_W-1:0];
		end else if (q > (ZFIX_W-FRAC_W+1)'(DEPTH_MAX)) begin
			r = DEPTH_MAX;
		end else begin
			r = q[DEPTH_W-1:0];
		end
		return r;
	endfunction

endpackage

### hdl/zvs_store.sv
`timescale 1ns / 1ps

module zvs_store import zvs_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  pixel_t            wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output pixel_t            rdata
);

	pixel_t mem [STORE_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/zvs_outbuf.sv
`timescale 1ns / 1ps

module zvs_outbuf import zvs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t res,
	output logic    can_take,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	logic    full_q;
	result_t res_q;

	assign can_take  = !full_q || !out_stall;
	assign out_valid = full_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push && can_take) begin
			full_q <= 1'b1;
		end else if (!out_stall) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_take) begin
			res_q <= res;
		end
	end

endmodule

### hdl/zvs_seq.sv
`timescale 1ns / 1ps

module zvs_seq import zvs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      depth_test_on,
	input  logic [COLOR_W-1:0]        marker_color,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic [COLOR_W-1:0]        vertex_color,
	input  logic signed [ZFIX_W-1:0]  vertex_depth,
	output logic                      mem_we,
	output logic [ADDR_W-1:0]         mem_waddr,
	output pixel_t                    mem_wdata,
	output logic                      mem_re,
	output logic [ADDR_W-1:0]         mem_raddr,
	input  pixel_t                    mem_rdata,
	output logic                      res_push,
	output result_t                   res,
	input  logic                      res_can_take
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic [ADDR_W-1:0]         clr_q;
	logic signed [POS_W-1:0]   x_q;
	logic signed [POS_W-1:0]   y_q;
	logic [COLOR_W-1:0]        color_q;
	logic signed [ZFIX_W-1:0]  depth_q;
	logic                      is_read_q;
	logic [1:0]                row_q;
	logic [1:0]                col_q;
	logic                      drawn_q;
	logic [COUNT_W-1:0]        cnt_q;
	logic [COLOR_W-1:0]        pcol_q;
	logic signed [DEPTH_W-1:0] pdep_q;

	logic                      v_s1;
	logic                      rd_s1;
	logic [ADDR_W-1:0]         addr_s1;

	logic                      accept;
	logic                      on_screen;
	logic signed [POS_W:0]     px;
	logic signed [POS_W:0]     py;
	logic                      pix_in;
	logic [ADDR_W-1:0]         pix_addr;
	logic                      nearer;
	logic                      pix_wr;
	pixel_t                    pix_wdata;
	pixel_t                    clear_word;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign on_screen = !pos_x[POS_W-1] && !pos_y[POS_W-1]
		&& (pos_x < POS_W'(SCREEN_W)) && (pos_y <= POS_W'(SCREEN_H - 2));

	// Row 0 is the row below the vertex, column 0 the one to its left.
	assign px = $signed({x_q[POS_W-1], x_q}) + $signed({{(POS_W-1){1'b0}}, col_q})
		- (POS_W+1)'(1);
	assign py = $signed({y_q[POS_W-1], y_q}) - $signed({{(POS_W-1){1'b0}}, row_q})
		+ (POS_W+1)'(1);

	assign pix_in = (px >= 0) && (px < $signed((POS_W+1)'(SCREEN_W)))
		&& (py >= 0) && (py < $signed((POS_W+1)'(SCREEN_H)));

	assign pix_addr = ADDR_W'(py[YW-1:0]) * ADDR_W'(SCREEN_W) + ADDR_W'(px[XW-1:0]);

	assign mem_re    = (state_q == S_ISSUE) && pix_in;
	assign mem_raddr = pix_addr;

	// Second half of the read-modify-write, in the cycle after the read.
	assign nearer = depth_q > $signed({mem_rdata.depth, {FRAC_W{1'b0}}});
	assign pix_wr = v_s1 && !rd_s1 && (!depth_test_on || nearer);

	always_comb begin
		if (depth_test_on) begin
			pix_wdata.color = color_q;
			pix_wdata.depth = round_depth(depth_q);
		end else begin
			pix_wdata.color = marker_color;
			pix_wdata.depth = mem_rdata.depth;
		end
	end

	assign clear_word.color = '0;
	assign clear_word.depth = DEPTH_MIN;

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = clear_word;
		end else begin
			mem_we    = pix_wr;
			mem_waddr = addr_s1;
			mem_wdata = pix_wdata;
		end
	end

	assign res_push             = (state_q == S_FINISH);
	assign res.was_drawn        = drawn_q;
	assign res.pixels_written   = cnt_q;
	assign res.pixel_color      = pcol_q;
	assign res.pixel_depth      = pdep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1   <= is_read_q;
		addr_s1 <= pix_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						x_q     <= pos_x;
						y_q     <= pos_y;
						color_q <= vertex_color;
						depth_q <= vertex_depth;
						cnt_q   <= '0;
						pcol_q  <= '0;
						pdep_q  <= '0;
						if (cmd_t'(cmd) == CMD_READ) begin
							is_read_q <= 1'b1;
							drawn_q   <= 1'b0;
							row_q     <= 2'd1;
							col_q     <= 2'd1;
							state_q   <= S_ISSUE;
						end else if (on_screen) begin
							is_read_q <= 1'b0;
							drawn_q   <= 1'b1;
							row_q     <= 2'd0;
							col_q     <= 2'd0;
							state_q   <= S_ISSUE;
						end else begin
							is_read_q <= 1'b0;
							drawn_q   <= 1'b0;
							state_q   <= S_FINISH;
						end
					end
				end
				S_ISSUE: begin
					if (is_read_q || (row_q == 2'd2 && col_q == 2'd2)) begin
						state_q <= S_DRAIN;
					end else if (col_q == 2'd2) begin
						col_q <= 2'd0;
						row_q <= row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_can_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (pix_wr) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (v_s1 && rd_s1) begin
				pcol_q <= mem_rdata.color;
				pdep_q <= mem_rdata.depth;
			end
		end
	end

endmodule

### hdl/zbuffered_vertex_splat_top.sv
`timescale 1ns / 1ps

// Point splat of a 3x3 vertex marker into a combined color and depth store
// of SCREEN_W x SCREEN_H pixels, with single-pixel readback. After reset the
// block first sweeps the whole store, one pixel per cycle, and takes no item
// until that pass is done; configuration writes are taken at any time. Items
// are handled one at a time. For an on-screen draw item, one read per
// on-screen marker pixel is issued each cycle into the store's read port,
// and the compare and write-back of each pixel follow on the write port in
// the cycle after its read. A finished result waits in an output register,
// and the next item is accepted meanwhile.

module zbuffered_vertex_splat_top import zvs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [COLOR_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic [COLOR_W-1:0]        vertex_color,
	input  logic signed [ZFIX_W-1:0]  vertex_depth,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      was_drawn,
	output logic [COUNT_W-1:0]        pixels_written,
	output logic [COLOR_W-1:0]        pixel_color,
	output logic signed [DEPTH_W-1:0] pixel_depth
);

	logic               depth_test_q;
	logic [COLOR_W-1:0] marker_q;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	pixel_t             mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	pixel_t             mem_rdata;

	logic               res_push;
	result_t            res;
	logic               res_can_take;
	result_t            out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_test_q <= 1'b0;
			marker_q     <= MARKER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEPTH_TEST:   depth_test_q <= cfg_data[0];
				REG_MARKER_COLOR: marker_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	zvs_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.depth_test_on (depth_test_q),
		.marker_color  (marker_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.vertex_color  (vertex_color),
		.vertex_depth  (vertex_depth),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.res_push      (res_push),
		.res           (res),
		.res_can_take  (res_can_take)
	);

	zvs_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	zvs_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.res       (res),
		.can_take  (res_can_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign was_drawn      = out_res.was_drawn;
	assign pixels_written = out_res.pixels_written;
	assign pixel_color    = out_res.pixel_color;
	assign pixel_depth    = out_res.pixel_depth;

endmodule

### hdl/zvs_check.sv
`timescale 1ns / 1ps

module zvs_check import zvs_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      was_drawn,
	input logic [COUNT_W-1:0]        pixels_written,
	input logic [COLOR_W-1:0]        pixel_color,
	input logic signed [DEPTH_W-1:0] pixel_depth
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixels_written) && $stable(pixel_color))
		else $error("stalled result item changed");

	// A drawn vertex never carries readback data.
	a_draw_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_drawn |-> pixel_color == '0 && pixel_depth == '0)
		else $error("draw result carries pixel data");

	// Reads and off-screen draws write nothing.
	a_count_needs_draw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !was_drawn |-> pixels_written == '0)
		else $error("pixels counted for an item that drew nothing");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixels_written <= COUNT_W'(9))
		else $error("more than nine marker pixels counted");

endmodule

bind zbuffered_vertex_splat_top zvs_check u_check (.*);

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import zvs_pkg::*;

	typedef struct {
		cmd_t                     cmd;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic [COLOR_W-1:0]       color;
		logic signed [ZFIX_W-1:0] depth;
	} splat_item_t;

	localparam int FRAC_STEPS [8] = '{-129, -128, -127, -1, 0, 1, 127, 128};
	localparam int DEPTH_EDGES [5] = '{-8388608, -8388607, -8388480, 8388480, 8388607};

	class splat_scoreboard;
		bit                        depth_on;
		logic [COLOR_W-1:0]        marker;
		logic [COLOR_W-1:0]        frame [int];
		logic signed [DEPTH_W-1:0] zbuf [int];
		result_t                   results_owed [$];
		int                        errors;
		int                        draws;
		int                        hits;
		int                        pixels;
		int                        reads;

		function new();
			depth_on = 1'b0;
			marker = MARKER_RESET;
			errors = 0;
			draws = 0;
			hits = 0;
			pixels = 0;
			reads = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [COLOR_W-1:0] v);
			case (r)
				REG_DEPTH_TEST: depth_on = v[0];
				REG_MARKER_COLOR: marker = v;
				default: ;
			endcase
		endfunction

		// Works out the result of one accepted item and updates the stores.
		function void note_item(splat_item_t it);
			result_t r;
			int x, y, d, idx, stored, z;
			r = '0;
			x = it.x;
			y = it.y;
			d = it.depth;
			if (it.cmd == CMD_READ) begin
				reads++;
				if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H) begin
					idx = x + y * SCREEN_W;
					r.pixel_color = frame.exists(idx) ? frame[idx] : '0;
					r.pixel_depth = zbuf.exists(idx) ? zbuf[idx] : DEPTH_MIN;
				end
			end else begin
				draws++;
				if (x >= 0 && x < SCREEN_W && y >= 0 && y <= SCREEN_H - 2) begin
					r.was_drawn = 1'b1;
					hits++;
					for (int py = y - 1; py <= y + 1; py++) begin
						for (int px = x - 1; px <= x + 1; px++) begin
							if (px < 0 || px >= SCREEN_W || py < 0)
								continue;
							idx = px + py * SCREEN_W;
							if (!depth_on) begin
								frame[idx] = marker;
							end else begin
								stored = zbuf.exists(idx) ? int'(zbuf[idx]) :
									int'($signed(DEPTH_MIN));
								if (d <= stored * 256)
									continue;
								// Halves round away from zero; the top saturates.
								z = (d >= 0) ? (d + 128) / 256 : -((-d + 128) / 256);
								if (z > 32767)
									z = 32767;
								frame[idx] = it.color;
								zbuf[idx] = DEPTH_W'(z);
							end
							r.pixels_written++;
						end
					end
					pixels += r.pixels_written;
				end
			end
			results_owed.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (results_owed.size() == 0) begin
				$error("unexpected result: was_drawn %0d pixels_written %0d color %h depth %0d",
					got.was_drawn, got.pixels_written, got.pixel_color, got.pixel_depth);
				errors++;
				return;
			end
			want = results_owed.pop_front();
			if (got.was_drawn !== want.was_drawn) begin
				$error("was_drawn: expected %0d, got %0d", want.was_drawn, got.was_drawn);
				errors++;
			end
			if (got.pixels_written !== want.pixels_written) begin
				$error("pixels_written: expected %0d, got %0d",
					want.pixels_written, got.pixels_written);
				errors++;
			end
			if (got.pixel_color !== want.pixel_color) begin
				$error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
				errors++;
			end
			if (got.pixel_depth !== want.pixel_depth) begin
				$error("pixel_depth: expected %0d, got %0d", want.pixel_depth, got.pixel_depth);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [0:0]                cfg_index;
	logic [COLOR_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      cmd;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;
	logic [COLOR_W-1:0]        vertex_color;
	logic signed [ZFIX_W-1:0]  vertex_depth;
	logic                      out_valid;
	logic                      out_stall;
	logic                      was_drawn;
	logic [COUNT_W-1:0]        pixels_written;
	logic [COLOR_W-1:0]        pixel_color;
	logic signed [DEPTH_W-1:0] pixel_depth;

	splat_scoreboard sb = new();
	int idle_pct = 0;
	int settings_seen = 1;

	zbuffered_vertex_splat_top dut (.*);

	always #5 clk = ~clk;

	function automatic splat_item_t item_of(cmd_t c, int x, int y, int color, int depth);
		splat_item_t it;
		it.cmd = c;
		it.x = POS_W'(x);
		it.y = POS_W'(y);
		it.color = COLOR_W'(color);
		it.depth = ZFIX_W'(depth);
		return it;
	endfunction

	// Mostly a small patch at the origin or against the far edges, so that
	// markers overlap and reads land on written pixels.
	function automatic int pick_coord(int span);
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(11);
		if (r < 92)
			return span - 1 - int'($urandom_range(3));
		if (r < 96)
			return -1 - int'($urandom_range(1));
		return span + int'($urandom_range(1));
	endfunction

	function automatic splat_item_t random_item();
		splat_item_t it;
		int base, idx;
		it.cmd = ($urandom_range(99) < 60) ? CMD_DRAW : CMD_READ;
		it.color = COLOR_W'($urandom);
		if ($urandom_range(99) < 10) begin
			it.cmd = cmd_t'($urandom_range(1));
			it.x = POS_W'($urandom);
			it.y = POS_W'($urandom);
		end else begin
			it.x = POS_W'(pick_coord(SCREEN_W));
			it.y = POS_W'(pick_coord(SCREEN_H));
		end
		case ($urandom_range(4))
			0: it.depth = ZFIX_W'($urandom);
			1: it.depth = ZFIX_W'(int'($urandom_range(8191)) - 4096);
			2, 3: begin
				// Land right around the depth already held at the vertex pixel.
				base = int'($urandom_range(65535)) - 32768;
				if (it.x >= 0 && it.x < SCREEN_W && it.y >= 0 && it.y < SCREEN_H) begin
					idx = int'(it.x) + int'(it.y) * SCREEN_W;
					if (sb.zbuf.exists(idx))
						base = sb.zbuf[idx];
				end
				it.depth = ZFIX_W'(base * 256 + FRAC_STEPS[$urandom_range(7)]);
			end
			default: it.depth = ZFIX_W'(DEPTH_EDGES[$urandom_range(4)]);
		endcase
		return it;
	endfunction

	task automatic write_reg(cfg_reg_t r, logic [COLOR_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(r, v);
		@(posedge clk);
	endtask

	task automatic send_item(splat_item_t it);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		pos_x <= it.x;
		pos_y <= it.y;
		vertex_color <= it.color;
		vertex_depth <= it.depth;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.results_owed.size() != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic run_phase(int n, bit depth_test, logic [COLOR_W-1:0] color, int pct);
		write_reg(REG_DEPTH_TEST, COLOR_W'(depth_test));
		write_reg(REG_MARKER_COLOR, color);
		settings_seen++;
		idle_pct = pct;
		repeat (n) send_item(random_item());
		drain();
	endtask

	initial begin : result_sink
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result({was_drawn, pixels_written, pixel_color, pixel_depth});
			if (hold == 0 && idle_pct > 0 && $urandom_range(99) < idle_pct)
				hold = $urandom_range(1, 19);
			out_stall <= (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DEPTH_TEST;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_DRAW;
		pos_x <= '0;
		pos_y <= '0;
		vertex_color <= '0;
		vertex_depth <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: fixed white marker, no depth test.
		idle_pct = 15;
		send_item(item_of(CMD_READ, 0, 0, 0, 0));
		send_item(item_of(CMD_DRAW, 0, 0, 24'h5a5a5a, 0));
		send_item(item_of(CMD_READ, 0, 0, 0, 0));
		send_item(item_of(CMD_READ, 1, 1, 0, 0));
		send_item(item_of(CMD_DRAW, SCREEN_W - 1, SCREEN_H - 2, 0, 0));
		send_item(item_of(CMD_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0));
		send_item(item_of(CMD_DRAW, 5, SCREEN_H - 1, 0, 0));
		send_item(item_of(CMD_DRAW, -1, 5, 0, 0));
		send_item(item_of(CMD_DRAW, SCREEN_W, 5, 0, 0));
		send_item(item_of(CMD_DRAW, -32768, 32767, 0, 0));
		send_item(item_of(CMD_READ, -1, 0, 0, 0));
		send_item(item_of(CMD_READ, 0, SCREEN_H, 0, 0));
		drain();

		// Depth test on: equal depth loses, rounding and saturation.
		write_reg(REG_DEPTH_TEST, COLOR_W'(1));
		write_reg(REG_MARKER_COLOR, '0);
		settings_seen++;
		send_item(item_of(CMD_DRAW, 10, 10, 24'hffffff, -8388608));
		send_item(item_of(CMD_DRAW, 10, 10, 24'h123456, -8388607));
		send_item(item_of(CMD_DRAW, 10, 10, 0, 384));
		send_item(item_of(CMD_DRAW, 10, 10, 24'h00ff00, 511));
		send_item(item_of(CMD_DRAW, 10, 10, 24'hffffff, 513));
		send_item(item_of(CMD_READ, 10, 10, 0, 0));
		send_item(item_of(CMD_DRAW, 20, 20, 24'habcdef, -384));
		send_item(item_of(CMD_READ, 20, 20, 0, 0));
		send_item(item_of(CMD_DRAW, 20, 20, 24'h010203, 8388607));
		send_item(item_of(CMD_READ, 21, 21, 0, 0));
		send_item(item_of(CMD_DRAW, 0, 0, 24'h800001, 0));
		send_item(item_of(CMD_READ, 0, 0, 0, 0));
		send_item(item_of(CMD_DRAW, 32767, -32768, 0, 0));
		drain();

		run_phase(200, 1'b1, '0, 25);
		run_phase(200, 1'b0, '0, 10);
		run_phase(200, 1'b0, COLOR_W'($urandom), 40);
		run_phase(200, 1'b0, MARKER_RESET, 0);
		run_phase(200, 1'b1, COLOR_W'($urandom), 20);
		run_phase(200, 1'b1, COLOR_W'($urandom), 0);

		$display("Covered %0d draw items (%0d on screen, %0d pixels written) and %0d reads",
			sb.draws, sb.hits, sb.pixels, sb.reads);
		$display("across %0d register settings, both depth modes and edge marker colors.",
			settings_seen);
		if (sb.errors == 0 && sb.results_owed.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// The clearing pass after reset alone sweeps every pixel of the store.
	initial begin : watchdog
		#60_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### zbuffered_vertex_splat_top.f
hdl/zvs_pkg.sv
hdl/zvs_store.sv
hdl/zvs_outbuf.sv
hdl/zvs_seq.sv
hdl/zbuffered_vertex_splat_top.sv
hdl/zvs_check.sv
dv/tb.sv
